>>> rtl/core/fsl_pkg.sv
// ----------------------------------------------------------------------------
// fsl_pkg
// shared types and constants of the fixed-string line filter
// ----------------------------------------------------------------------------
package fsl_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAT_LEN_W   = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [BYTE_W-1:0] TERM_RESET = 8'd13;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_TERMINATOR = 3'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEND
    } fsl_state_t;

    // controller to datapath
    typedef struct packed {
        logic store_byte;   // store and shift the input byte
        logic check;        // compare window with pattern
        logic clear_line;   // drop line state
        logic rd_first;     // read first stored byte
        logic rd_next;      // read following stored byte
    } fsl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic line_end;     // input item ends the line
        logic matched;      // pattern seen in current line
        logic last_byte;    // output byte is the last of the line
    } fsl_stat_t;

endpackage

>>> rtl/core/fsl_if.sv
// ----------------------------------------------------------------------------
// fsl_if
// valid/ready channels of the fixed-string line filter
// ----------------------------------------------------------------------------
interface fsl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface fsl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       last_of_line;
    logic       truncated;

    modport source (output valid, output line_byte, output last_of_line,
                    output truncated, input ready);
    modport sink (input valid, input line_byte, input last_of_line,
                  input truncated, output ready);
endinterface

interface fsl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/fsl_datapath.sv
// ----------------------------------------------------------------------------
// fsl_datapath
// line store, match window, pattern registers and replay read port
// ----------------------------------------------------------------------------
module fsl_datapath
    import fsl_pkg::*;
#(
    parameter int LINE_BYTES    = 64,
    parameter int PATTERN_BYTES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  fsl_cmd_t               cmd,
    output fsl_stat_t              stat,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   end_of_input,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [BYTE_W-1:0]      line_byte,
    output logic                   last_of_line,
    output logic                   truncated
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam int FW = $clog2(PATTERN_BYTES + 1);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [PAT_LEN_W-1:0]  pattern_length_reg;
    logic [BYTE_W-1:0]     terminator_reg;

    logic [BYTE_W-1:0]     window_reg [PATTERN_BYTES];
    logic [FW-1:0]         fill_reg;
    logic                  matched_reg;
    logic [LW-1:0]         length_reg;
    logic                  overflow_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic [AW-1:0]         rd_idx_next;
    logic [BYTE_W-1:0]     rd_data_reg;

    logic [BYTE_W-1:0]     store_mem [LINE_BYTES];

    logic [2*CFG_DATA_W-1:0] pattern_all;
    logic [PATTERN_BYTES:1]  hit_len;
    logic                    hit;
    logic                    store_room;

    assign pattern_all = {pattern_high_reg, pattern_low_reg};
    assign store_room  = (length_reg < LW'(LINE_BYTES));

    // per pattern length: window oldest-to-newest equals pattern head
    always_comb
    begin
        for (int l = 1; l <= PATTERN_BYTES; l++)
        begin
            hit_len[l] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (window_reg[l-1-k] != pattern_all[8*k +: 8])
                    hit_len[l] = 1'b0;
            end
        end
    end

    always_comb
    begin
        hit = 1'b0;
        for (int l = 1; l <= PATTERN_BYTES; l++)
        begin
            if (pattern_length_reg == PAT_LEN_W'(l) &&
                (PAT_LEN_W + 1)'(fill_reg) >= (PAT_LEN_W + 1)'(l))
                hit = hit_len[l];
        end
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_first)
            rd_idx_next = '0;
        else if (cmd.rd_next)
            rd_idx_next = rd_idx_reg + AW'(1);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            terminator_reg     <= TERM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:     pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH:    pattern_high_reg   <= cfg_data;
                CFG_PATTERN_LENGTH:  pattern_length_reg <= cfg_data[PAT_LEN_W-1:0];
                CFG_LINE_TERMINATOR: terminator_reg     <= cfg_data[BYTE_W-1:0];
                default:             ;
            endcase
        end
    end

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_BYTES; i++)
                window_reg[i] <= '0;
            fill_reg     <= '0;
            matched_reg  <= 1'b0;
            length_reg   <= '0;
            overflow_reg <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            if (cmd.clear_line)
            begin
                for (int i = 0; i < PATTERN_BYTES; i++)
                    window_reg[i] <= '0;
                fill_reg     <= '0;
                matched_reg  <= 1'b0;
                length_reg   <= '0;
                overflow_reg <= 1'b0;
            end
            else if (cmd.store_byte)
            begin
                for (int i = PATTERN_BYTES - 1; i > 0; i--)
                    window_reg[i] <= window_reg[i-1];
                window_reg[0] <= data_byte;
                if (fill_reg < FW'(PATTERN_BYTES))
                    fill_reg <= fill_reg + FW'(1);
                if (store_room)
                    length_reg <= length_reg + LW'(1);
                else
                    overflow_reg <= 1'b1;
            end
            else if (cmd.check && hit)
            begin
                matched_reg <= 1'b1;
            end
        end
    end

    // line store memory
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte && store_room)
            store_mem[length_reg[AW-1:0]] <= data_byte;
        if (cmd.rd_first || cmd.rd_next)
            rd_data_reg <= store_mem[rd_idx_next];
    end

    assign stat.line_end  = end_of_input || (data_byte == terminator_reg);
    assign stat.matched   = matched_reg;
    assign stat.last_byte = ((LW'(rd_idx_reg) + LW'(1)) == length_reg);

    assign line_byte    = rd_data_reg;
    assign last_of_line = stat.last_byte;
    assign truncated    = overflow_reg;

endmodule

>>> rtl/core/fsl_ctrl.sv
// ----------------------------------------------------------------------------
// fsl_ctrl
// sequencer for byte intake, match check and line replay
// ----------------------------------------------------------------------------
module fsl_ctrl
    import fsl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  fsl_stat_t stat,
    output fsl_cmd_t  cmd
);

    fsl_state_t state_reg;
    fsl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!stat.line_end)
                        state_next = ST_CHECK;
                    else if (stat.matched)
                        state_next = ST_SEND;
                end
            end
            ST_CHECK:
                state_next = ST_IDLE;
            ST_SEND:
            begin
                if (out_ready && stat.last_byte)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!stat.line_end)
                        cmd.store_byte = 1'b1;
                    else if (stat.matched)
                        cmd.rd_first = 1'b1;
                    else
                        cmd.clear_line = 1'b1;
                end
            end
            ST_CHECK:
                cmd.check = 1'b1;
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.last_byte)
                        cmd.clear_line = 1'b1;
                    else
                        cmd.rd_next = 1'b1;
                end
            end
            default:
                ;
        endcase
    end

endmodule

>>> rtl/core/fixed_string_line_filter.sv
// ----------------------------------------------------------------------------
// fixed_string_line_filter
// passes on whole lines of a byte stream that contain a fixed pattern
// ----------------------------------------------------------------------------
//   channel  dir  payload                                 transfer when
//   in_ch    in   data_byte, end_of_input                 valid & ready
//   out_ch   out  line_byte, last_of_line, truncated      valid & ready
//   cfg_ch   in   index (0..3), data (64 bits)            valid & ready
//
// a text byte is handled in two steps: store and window shift, then pattern compare
// a terminator or end-of-input item needs no compare; for a matched line the
// replay then gives one byte per cycle while out_ch is ready, from the line store read port
// reset clears line state, pattern registers and sets the terminator to CR
// out_ch stalls hold the replay; in_ch is not taken until the line is sent
// ----------------------------------------------------------------------------
module fixed_string_line_filter
    import fsl_pkg::*;
#(
    parameter int LINE_BYTES    = 64,
    parameter int PATTERN_BYTES = 16
)
(
    input logic      clk,
    input logic      rst_n,
    fsl_in_if.sink   in_ch,
    fsl_out_if.source out_ch,
    fsl_cfg_if.sink  cfg_ch
);

    fsl_cmd_t  cmd;
    fsl_stat_t stat;

    // config writes are registered, always ready
    assign cfg_ch.ready = 1'b1;

    // state machine: intake, compare, replay
    fsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage, window compare and output register
    fsl_datapath #(
        .LINE_BYTES    (LINE_BYTES),
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .data_byte    (in_ch.data_byte),
        .end_of_input (in_ch.end_of_input),
        .cfg_we       (cfg_ch.valid),
        .cfg_index    (cfg_ch.index),
        .cfg_data     (cfg_ch.data),
        .line_byte    (out_ch.line_byte),
        .last_of_line (out_ch.last_of_line),
        .truncated    (out_ch.truncated)
    );

endmodule
